FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the dropout block.
// Depends on nothing; simulation builds get the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: hw/rtl/hid_pkg.sv
// Package of the hashed inverted dropout block: hash constants, register addresses, types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package hid_pkg;
    localparam logic [31:0] K_SEED_HI = 32'h9e3779b9;
    localparam logic [31:0] K_RUN_LO  = 32'h85ebca6b;
    localparam logic [31:0] K_RUN_HI  = 32'hc2b2ae35;
    localparam logic [31:0] K_IDX_LO  = 32'h27d4eb2d;
    localparam logic [31:0] K_IDX_HI  = 32'h165667b1;
    localparam logic [31:0] K_FIN_A   = 32'h7feb352d;
    localparam logic [31:0] K_FIN_B   = 32'h846ca68b;
    localparam logic [31:0] QNAN      = 32'h7fc00000;
    localparam logic [31:0] SCALE_ONE = 32'h3f800000;
    localparam int          ADDR_BITS = 5;
    localparam logic [ADDR_BITS-1:0] A_SEED  = 5'd0;
    localparam logic [ADDR_BITS-1:0] A_RUN   = 5'd8;
    localparam logic [ADDR_BITS-1:0] A_THR   = 5'd16;
    localparam logic [ADDR_BITS-1:0] A_SCALE = 5'd24;

    // Item handed from front to back: value, hash base, index halves, last flag.
    typedef struct packed {
        logic [31:0] value;
        logic [31:0] h_base;
        logic [31:0] idx_lo;
        logic [31:0] idx_hi;
        logic        last;
    } front_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic        kept;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [63:0] seed;
        logic [63:0] run_id;
        logic [24:0] threshold;
        logic [31:0] scale;
    } cfg_t;
endpackage
`default_nettype wire

FILE: hw/rtl/hid_fpmul.sv
// Pipelined FP32 multiplier, round to nearest even, canonical NaN, subnormals kept.
// Three register stages; depends on hid_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hid_fpmul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [31:0] y
);
    // Stage 1: unpack, classify, multiply significands.
    logic        s1_sign_reg, s1_special_reg;
    logic [31:0] s1_special_val_reg;
    logic [47:0] s1_prod_reg;
    logic signed [10:0] s1_exp_reg;

    logic        sa, sb, sgn;
    logic [7:0]  ea, eb;
    logic [22:0] fa, fb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [23:0] ma, mb;
    logic [31:0] sp_val;
    logic        sp;

    always_comb
    begin
        sa = a[31]; sb = b[31]; sgn = sa ^ sb;
        ea = a[30:23]; eb = b[30:23];
        fa = a[22:0]; fb = b[22:0];
        a_nan = (ea == 8'hff) && (fa != 23'd0);
        b_nan = (eb == 8'hff) && (fb != 23'd0);
        a_inf = (ea == 8'hff) && (fa == 23'd0);
        b_inf = (eb == 8'hff) && (fb == 23'd0);
        a_zero = (ea == 8'd0) && (fa == 23'd0);
        b_zero = (eb == 8'd0) && (fb == 23'd0);
        ma = {(ea != 8'd0), fa};
        mb = {(eb != 8'd0), fb};
        sp = 1'b1;
        sp_val = {sgn, 31'd0};
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
        begin
            sp_val = hid_pkg::QNAN;
        end
        else if (a_inf || b_inf)
        begin
            sp_val = {sgn, 8'hff, 23'd0};
        end
        else if (a_zero || b_zero)
        begin
            sp_val = {sgn, 31'd0};
        end
        else
        begin
            sp = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sign_reg        <= sgn;
            s1_special_reg     <= sp;
            s1_special_val_reg <= sp_val;
            s1_prod_reg        <= ma * mb;
            // Value = prod * 2^(exp - 127 - 46); subnormal exponents count as 1.
            s1_exp_reg <= $signed({3'd0, (ea == 8'd0) ? 8'd1 : ea})
                        + $signed({3'd0, (eb == 8'd0) ? 8'd1 : eb}) - 11'sd127;
        end
    end

    // Stage 2: leading-zero count over the product, for normalization.
    logic [5:0]  lz;
    always_comb
    begin
        lz = 6'd48;
        for (int i = 0; i < 48; i++)
        begin
            if (s1_prod_reg[i])
            begin
                lz = 6'(47 - i);
            end
        end
    end

    logic        s2_sign_reg, s2_special_reg;
    logic [31:0] s2_special_val_reg;
    logic [47:0] s2_prod_reg;
    logic [5:0]  s2_lz_reg;
    logic signed [10:0] s2_exp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_sign_reg        <= s1_sign_reg;
            s2_special_reg     <= s1_special_reg;
            s2_special_val_reg <= s1_special_val_reg;
            s2_prod_reg        <= s1_prod_reg;
            s2_lz_reg          <= lz;
            s2_exp_reg         <= s1_exp_reg;
        end
    end

    // Stage 3: shift so bit 47 is the leading one, clamp to subnormal range, round.
    logic signed [10:0] e_norm;
    logic [47:0] shifted;
    logic [73:0] wide;
    logic [10:0] rshift;
    logic [23:0] mant;
    logic        guard, sticky, rnd;
    logic [24:0] mant_r;
    logic [8:0]  e_fin;
    logic [31:0] res;

    always_comb
    begin
        // Leading one at bit 47 stands for 2^(e_norm-127) with e_norm = exp + 1 - lz.
        shifted = s2_prod_reg << s2_lz_reg;
        e_norm = s2_exp_reg + 11'sd1 - $signed({5'd0, s2_lz_reg});
        rshift = 11'd0;
        if (e_norm < 11'sd1)
        begin
            rshift = (11'sd1 - e_norm > 11'sd26) ? 11'd26 : 11'(11'sd1 - e_norm);
        end
        wide = {shifted, 26'd0} >> rshift;
        mant = wide[73:50];
        guard = wide[49];
        sticky = |wide[48:0];
        rnd = guard && (sticky || mant[0]);
        mant_r = {1'b0, mant} + {24'd0, rnd};
        if (e_norm < 11'sd1)
        begin
            e_fin = mant_r[23] ? 9'd1 : 9'd0;
            res = {s2_sign_reg, e_fin[7:0], mant_r[22:0]};
        end
        else
        begin
            if (mant_r[24])
            begin
                e_fin = 9'(e_norm + 11'sd1);
            end
            else
            begin
                e_fin = 9'(e_norm);
            end
            if (e_norm + (mant_r[24] ? 11'sd1 : 11'sd0) >= 11'sd255)
            begin
                res = {s2_sign_reg, 8'hff, 23'd0};
            end
            else
            begin
                res = {s2_sign_reg, e_fin[7:0],
                       mant_r[24] ? mant_r[23:1] : mant_r[22:0]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y <= '0;
        end
        else if (en)
        begin
            y <= s2_special_reg ? s2_special_val_reg : res;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/hid_front.sv
// Front end: holds the element index, mixes the configuration part of the hash.
// Depends on hid_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hid_front #(
    parameter int INDEX_BITS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [31:0]           value_in,
    input  wire logic                  is_last,
    input  wire hid_pkg::cfg_t         cfg,
    output hid_pkg::front_item_t       item
);
    logic [INDEX_BITS-1:0] index_reg, index_next;
    logic [63:0] idx64;

    assign idx64 = 64'(index_reg);
    assign index_next = is_last ? '0 : index_reg + INDEX_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
        end
        else if (accept)
        begin
            index_reg <= index_next;
        end
    end

    logic [31:0] h_base;
    assign h_base = cfg.seed[31:0] ^ 32'(cfg.seed[63:32] * hid_pkg::K_SEED_HI)
                  ^ 32'(cfg.run_id[31:0] * hid_pkg::K_RUN_LO)
                  ^ 32'(cfg.run_id[63:32] * hid_pkg::K_RUN_HI);

    always_comb
    begin
        item.value  = value_in;
        item.h_base = h_base;
        item.idx_lo = idx64[31:0];
        item.idx_hi = idx64[63:32];
        item.last   = is_last;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/hid_back.sv
// Back end: finishes the hash, compares, scales kept elements, output queue.
// Depends on hid_pkg, hid_fpmul and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hid_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire hid_pkg::front_item_t  in_item,
    output logic                       in_ready,
    input  wire hid_pkg::cfg_t         cfg,
    output logic                       out_valid,
    output hid_pkg::result_t           out_item,
    input  wire logic                  out_pop
);
    localparam int STAGES = 6;
    localparam int DEPTH  = 8;
    localparam int AW     = 3;
    localparam logic [AW:0] FULL_COUNT = (AW+1)'(DEPTH);

    // Pipeline advances as a whole; the output queue reserves room for all in flight.
    logic [STAGES-1:0] vld_reg;
    logic [AW:0]       count_reg;
    logic [AW-1:0]     wp_reg, rp_reg;
    logic              adv;
    logic [3:0]        inflight;
    logic [4:0]        reserved;

    always_comb
    begin
        inflight = '0;
        for (int i = 0; i < STAGES; i++)
        begin
            inflight = inflight + {3'd0, vld_reg[i]};
        end
    end
    assign reserved = {1'b0, count_reg} + {1'b0, inflight};
    assign in_ready = reserved < 5'(DEPTH);
    assign adv = 1'b1;

    // Stage 0: index multiplies.
    logic [31:0] p0_lo_reg, p0_hi_reg, p0_base_reg, p0_val_reg;
    logic        p0_last_reg;
    // Stage 1: xor, first fold, multiply A.
    logic [31:0] p1_h_reg, p1_val_reg;
    logic        p1_last_reg;
    // Stage 2: second fold, multiply B.
    logic [31:0] p2_h_reg, p2_val_reg;
    logic        p2_last_reg;
    logic [31:0] h0, h1, h2;

    assign h0 = p0_base_reg ^ p0_lo_reg ^ p0_hi_reg;
    assign h1 = h0 ^ (h0 >> 16);
    assign h2 = p1_h_reg ^ (p1_h_reg >> 15);

    always_ff @(posedge clk)
    begin
        p0_lo_reg   <= 32'(in_item.idx_lo * hid_pkg::K_IDX_LO);
        p0_hi_reg   <= 32'(in_item.idx_hi * hid_pkg::K_IDX_HI);
        p0_base_reg <= in_item.h_base;
        p0_val_reg  <= in_item.value;
        p0_last_reg <= in_item.last;
        p1_h_reg    <= 32'(h1 * hid_pkg::K_FIN_A);
        p1_val_reg  <= p0_val_reg;
        p1_last_reg <= p0_last_reg;
        p2_h_reg    <= 32'(h2 * hid_pkg::K_FIN_B);
        p2_val_reg  <= p1_val_reg;
        p2_last_reg <= p1_last_reg;
    end

    logic [31:0] hf;
    logic        keep;
    assign hf = p2_h_reg ^ (p2_h_reg >> 16);
    assign keep = {1'b0, hf[31:8]} >= cfg.threshold;

    // Multiplier runs beside three delay stages holding keep and last.
    logic [31:0] prod;
    hid_fpmul u_mul (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .a(p2_val_reg), .b(cfg.scale), .y(prod)
    );
    logic [2:0] keep_d_reg, last_d_reg;
    always_ff @(posedge clk)
    begin
        keep_d_reg <= {keep_d_reg[1:0], keep};
        last_d_reg <= {last_d_reg[1:0], p2_last_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid && in_ready};
        end
    end

    hid_pkg::result_t mem [DEPTH];
    logic wr, rd;
    assign wr = vld_reg[STAGES-1];
    assign rd = out_pop && out_valid;
    assign out_valid = count_reg != '0;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wp_reg] <= '{value: keep_d_reg[2] ? prod : 32'd0,
                             kept: keep_d_reg[2], last: last_d_reg[2]};
        end
    end
    assign out_item = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= wp_reg + AW'(1);
            end
            if (rd)
            begin
                rp_reg <= rp_reg + AW'(1);
            end
            count_reg <= count_reg + {{AW{1'b0}}, wr} - {{AW{1'b0}}, rd};
        end
    end

    `ASSERT_NEVER(a_no_overflow, clk, rst_n, wr && !rd && count_reg == FULL_COUNT, "queue overflow")
    `ASSERT_NEVER(a_no_underflow, clk, rst_n, rd && count_reg == '0, "queue underflow")
    `ASSERT_CLK(a_room, clk, rst_n, reserved <= 5'(DEPTH), "reservation broken")
endmodule
`default_nettype wire

FILE: hw/rtl/hashed_inverted_dropout.sv
// Top level of the hashed inverted dropout block: register port, front, back.
// Depends on hid_pkg, hid_front and hid_back.
//
// Usage: FP32 elements enter through push/full with value_in and is_last.
// Each item hashes a running element index with seed and run_id; when the
// top 24 hash bits reach the threshold the element is scaled by the scale
// register (round to nearest even), otherwise +0 comes out. The index returns
// to zero after an item marked last. Results leave in order through empty/pop.
// One item a cycle is taken while the receiver keeps up, since the six-stage
// hash and multiply pipeline never holds. The output queue holds eight
// results; full rises when queued plus in-flight results fill it, so a
// stalled receiver stops intake without loss. Reset clears the index, the
// queue and the registers (scale reads back 1.0). Registers are to be written
// through the APB port only while idle; the block does not enforce it. Seed
// at 0, run_id at 8, threshold at 16, scale at 24; paddr[4:3] selects.
`timescale 1ns / 1ps
`default_nettype none
module hashed_inverted_dropout #(
    parameter int INDEX_BITS = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] value_in,
    input  wire logic        is_last,
    output logic             empty,
    input  wire logic        pop,
    output logic      [31:0] value_out,
    output logic             kept,
    output logic             last_out
);
    hid_pkg::cfg_t cfg_reg;
    logic wr_en;
    logic [4:0] reg_addr;
    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign reg_addr = {paddr[4:3], 3'b000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.seed      <= '0;
            cfg_reg.run_id    <= '0;
            cfg_reg.threshold <= '0;
            cfg_reg.scale     <= hid_pkg::SCALE_ONE;
        end
        else if (wr_en)
        begin
            unique case (reg_addr)
                hid_pkg::A_SEED:  cfg_reg.seed      <= pwdata;
                hid_pkg::A_RUN:   cfg_reg.run_id    <= pwdata;
                hid_pkg::A_THR:   cfg_reg.threshold <= pwdata[24:0];
                hid_pkg::A_SCALE: cfg_reg.scale     <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_addr)
            hid_pkg::A_SEED:  prdata = cfg_reg.seed;
            hid_pkg::A_RUN:   prdata = cfg_reg.run_id;
            hid_pkg::A_THR:   prdata = {39'd0, cfg_reg.threshold};
            hid_pkg::A_SCALE: prdata = {32'd0, cfg_reg.scale};
            default:          prdata = '0;
        endcase
    end

    logic ready, accept, out_valid;
    hid_pkg::front_item_t f_item;
    hid_pkg::result_t     r_item;
    assign full = !ready;
    assign accept = push && ready;

    hid_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .accept(accept),
        .value_in(value_in), .is_last(is_last), .cfg(cfg_reg), .item(f_item)
    );

    hid_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(push), .in_item(f_item),
        .in_ready(ready), .cfg(cfg_reg), .out_valid(out_valid),
        .out_item(r_item), .out_pop(pop)
    );

    assign empty = !out_valid;
    assign value_out = r_item.value;
    assign kept = r_item.kept;
    assign last_out = r_item.last;
endmodule
`default_nettype wire
